### hw/rtl/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  // Default hue width, one full turn is 2^HUE_BITS
  localparam int unsigned HueBitsDefault = 16;

  // Width of one color channel
  localparam int unsigned ChanW = 8;

  // Color wheel sector, from the integer part of six times the hue
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  // Floor of x / 255 for x below 255 * 256
  function automatic logic [ChanW-1:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = 17'(x) + 17'd1 + 17'(x[15:8]);
    return sum[15:8];
  endfunction

endpackage

### hw/rtl/hsv2rgb_sector.sv
module hsv2rgb_sector
  import hsv2rgb_pkg::*;
#(
  parameter int unsigned HUE_BITS = HueBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [HUE_BITS-1:0] hue_i,
  input  logic [ChanW-1:0]    sat_i,
  input  logic [ChanW-1:0]    val_i,
  output logic                valid_o,
  output sector_e             sector_o,
  output logic [HUE_BITS-1:0] frac_o,
  output logic [HUE_BITS:0]   frac_inv_o,
  output logic [ChanW-1:0]    sat_o,
  output logic [ChanW-1:0]    val_o
);

  localparam logic [HUE_BITS:0] HueOne = (HUE_BITS+1)'(1) << HUE_BITS;

  logic [HUE_BITS+2:0] six;
  logic                valid_q;
  sector_e             sector_q;
  logic [HUE_BITS-1:0] frac_q;
  logic [HUE_BITS:0]   frac_inv_q;
  logic [ChanW-1:0]    sat_q;
  logic [ChanW-1:0]    val_q;

  // Scale hue by six: sector in the top bits, fraction below
  assign six = (HUE_BITS+3)'(hue_i) * (HUE_BITS+3)'(6);

  // Advance the valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Hold the word with its sector and fraction
  always_ff @(posedge clk_i) begin
    sector_q   <= sector_e'(six[HUE_BITS+2:HUE_BITS]);
    frac_q     <= six[HUE_BITS-1:0];
    frac_inv_q <= HueOne - (HUE_BITS+1)'(six[HUE_BITS-1:0]);
    sat_q      <= sat_i;
    val_q      <= val_i;
  end

  assign valid_o    = valid_q;
  assign sector_o   = sector_q;
  assign frac_o     = frac_q;
  assign frac_inv_o = frac_inv_q;
  assign sat_o      = sat_q;
  assign val_o      = val_q;

endmodule

### hw/rtl/hsv2rgb_scale.sv
module hsv2rgb_scale
  import hsv2rgb_pkg::*;
#(
  parameter int unsigned HUE_BITS = HueBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  sector_e             sector_i,
  input  logic [HUE_BITS-1:0] frac_i,
  input  logic [HUE_BITS:0]   frac_inv_i,
  input  logic [ChanW-1:0]    sat_i,
  input  logic [ChanW-1:0]    val_i,
  output logic                valid_o,
  output sector_e             sector_o,
  output logic [ChanW-1:0]    val_o,
  output logic [ChanW-1:0]    p_o,
  output logic [ChanW-1:0]    q_o,
  output logic [ChanW-1:0]    t_o
);

  localparam int unsigned NumW  = HUE_BITS + 8;
  localparam int unsigned ProdW = HUE_BITS + 16;
  // 255 * 2^HUE_BITS, the scaled value of 1.0
  localparam logic [NumW:0] Full = (NumW+1)'(255) << HUE_BITS;

  // Stage A: saturation products
  logic [2:0]          valid_q;
  sector_e             sec_a_q, sec_b_q, sec_c_q;
  logic [ChanW-1:0]    val_a_q, val_b_q, val_c_q;
  logic [NumW-1:0]     sf_q;
  logic [NumW:0]       sg_q;
  logic [15:0]         pn_a_q, pn_b_q;
  // Stage B: value times numerators
  logic [NumW-1:0]     nq, nt;
  logic [ProdW-1:0]    prod_q_q, prod_t_q;
  // Stage C: divided channels
  logic [ChanW-1:0]    p_q, q_q, t_q;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  // Stage A: multiply saturation by f and by 1-f, value by 1-s
  always_ff @(posedge clk_i) begin
    sec_a_q <= sector_i;
    val_a_q <= val_i;
    sf_q    <= NumW'(sat_i) * NumW'(frac_i);
    sg_q    <= (NumW+1)'(sat_i) * (NumW+1)'(frac_inv_i);
    pn_a_q  <= 16'(val_i) * 16'(8'd255 - sat_i);
  end

  // Stage B: form the numerators and scale them by the value
  assign nq = Full[NumW-1:0] - sf_q;
  assign nt = NumW'(Full - sg_q);

  always_ff @(posedge clk_i) begin
    sec_b_q  <= sec_a_q;
    val_b_q  <= val_a_q;
    pn_b_q   <= pn_a_q;
    prod_q_q <= ProdW'(val_a_q) * ProdW'(nq);
    prod_t_q <= ProdW'(val_a_q) * ProdW'(nt);
  end

  // Stage C: drop the hue scale and divide by 255
  always_ff @(posedge clk_i) begin
    sec_c_q <= sec_b_q;
    val_c_q <= val_b_q;
    p_q     <= div255(pn_b_q);
    q_q     <= div255(prod_q_q[ProdW-1:HUE_BITS]);
    t_q     <= div255(prod_t_q[ProdW-1:HUE_BITS]);
  end

  assign valid_o  = valid_q[2];
  assign sector_o = sec_c_q;
  assign val_o    = val_c_q;
  assign p_o      = p_q;
  assign q_o      = q_q;
  assign t_o      = t_q;

endmodule

### hw/rtl/hsv2rgb_select.sv
module hsv2rgb_select
  import hsv2rgb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  sector_e          sector_i,
  input  logic [ChanW-1:0] val_i,
  input  logic [ChanW-1:0] p_i,
  input  logic [ChanW-1:0] q_i,
  input  logic [ChanW-1:0] t_i,
  output logic             valid_o,
  output logic [ChanW-1:0] red_o,
  output logic [ChanW-1:0] green_o,
  output logic [ChanW-1:0] blue_o
);

  logic             valid_q;
  logic [ChanW-1:0] red_d, green_d, blue_d;
  logic [ChanW-1:0] red_q, green_q, blue_q;

  // Route v, p, q and t to the channels by sector
  always_comb begin
    unique case (sector_i)
      SEC_RED_YEL: begin red_d = val_i; green_d = t_i;   blue_d = p_i;   end
      SEC_YEL_GRN: begin red_d = q_i;   green_d = val_i; blue_d = p_i;   end
      SEC_GRN_CYN: begin red_d = p_i;   green_d = val_i; blue_d = t_i;   end
      SEC_CYN_BLU: begin red_d = p_i;   green_d = q_i;   blue_d = val_i; end
      SEC_BLU_MAG: begin red_d = t_i;   green_d = p_i;   blue_d = val_i; end
      default:     begin red_d = val_i; green_d = p_i;   blue_d = q_i;   end
    endcase
  end

  // Advance the strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Hold the output word
  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  assign valid_o = valid_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

### hw/rtl/hsv_to_rgb_converter.sv
// HSV to RGB color converter.
// Input channel: present hue_i, saturation_i and brightness_i with start_i high;
// the word is taken at the rising edge where start_i is high and busy_o is low.
// busy_o is always low: the pipeline takes one word on every clock cycle.
// Hue is a fraction of a full turn in HUE_BITS bits and wraps naturally;
// saturation and brightness use 255 for 1.0.
// Output channel: red_o, green_o and blue_o are valid for exactly one cycle
// while valid_o is high. Throughput is one word per cycle; the pipeline has
// five register stages: sector split, saturation products, value products,
// divide by 255, and channel select.
// The receiver cannot stall the output; it must take each word as it shows.
// Reset clears the valid bits, so words in flight are dropped and no strobe
// follows until new words are started.
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
#(
  parameter int unsigned HUE_BITS = HueBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [HUE_BITS-1:0] hue_i,
  input  logic [ChanW-1:0]    saturation_i,
  input  logic [ChanW-1:0]    brightness_i,
  output logic                valid_o,
  output logic [ChanW-1:0]    red_o,
  output logic [ChanW-1:0]    green_o,
  output logic [ChanW-1:0]    blue_o
);

  logic                s1_valid;
  sector_e             s1_sector;
  logic [HUE_BITS-1:0] s1_frac;
  logic [HUE_BITS:0]   s1_frac_inv;
  logic [ChanW-1:0]    s1_sat, s1_val;
  logic                s2_valid;
  sector_e             s2_sector;
  logic [ChanW-1:0]    s2_val, s2_p, s2_q, s2_t;

  // Never stall the input
  assign busy_o = 1'b0;

  // Split hue into sector and fraction
  hsv2rgb_sector #(
    .HUE_BITS(HUE_BITS)
  ) u_sector (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start_i & ~busy_o),
    .hue_i      (hue_i),
    .sat_i      (saturation_i),
    .val_i      (brightness_i),
    .valid_o    (s1_valid),
    .sector_o   (s1_sector),
    .frac_o     (s1_frac),
    .frac_inv_o (s1_frac_inv),
    .sat_o      (s1_sat),
    .val_o      (s1_val)
  );

  // Compute p, q and t
  hsv2rgb_scale #(
    .HUE_BITS(HUE_BITS)
  ) u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s1_valid),
    .sector_i   (s1_sector),
    .frac_i     (s1_frac),
    .frac_inv_i (s1_frac_inv),
    .sat_i      (s1_sat),
    .val_i      (s1_val),
    .valid_o    (s2_valid),
    .sector_o   (s2_sector),
    .val_o      (s2_val),
    .p_o        (s2_p),
    .q_o        (s2_q),
    .t_o        (s2_t)
  );

  // Route to the output channels
  hsv2rgb_select u_select (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s2_valid),
    .sector_i (s2_sector),
    .val_i    (s2_val),
    .p_i      (s2_p),
    .q_i      (s2_q),
    .t_i      (s2_t),
    .valid_o  (valid_o),
    .red_o    (red_o),
    .green_o  (green_o),
    .blue_o   (blue_o)
  );

endmodule

### bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hsv2rgb_pkg::*;

  localparam int unsigned HueW      = HueBitsDefault;
  localparam int unsigned ClkPeriod = 10;
  localparam int unsigned RandWords = 1300;
  localparam int unsigned DrainWait = 12;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] val;
  } hsv_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             start_i      = 1'b0;
  logic [HueW-1:0]  hue_i        = '0;
  logic [ChanW-1:0] saturation_i = '0;
  logic [ChanW-1:0] brightness_i = '0;
  logic             busy_o;
  logic             valid_o;
  logic [ChanW-1:0] red_o;
  logic [ChanW-1:0] green_o;
  logic [ChanW-1:0] blue_o;

  hsv_t        pending_hsv[$];
  rgb_t        expected_rgb[$];
  int unsigned words_queued  = 0;
  int unsigned words_taken   = 0;
  int unsigned words_checked = 0;
  int unsigned mismatches    = 0;
  int unsigned sector_hits[6];
  int unsigned gap_left      = 0;
  int unsigned calm_left     = 0;

  hsv_to_rgb_converter #(
    .HUE_BITS(HueW)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .hue_i       (hue_i),
    .saturation_i(saturation_i),
    .brightness_i(brightness_i),
    .valid_o     (valid_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Compute the color a word should turn into, exact floor at each channel
  function automatic rgb_t hsv_to_rgb_predict(hsv_t c);
    longint unsigned one, six, frac, full, v, s, p, q, t;
    sector_e         sec;
    rgb_t            res;
    one  = longint'(1) << HueW;
    six  = longint'(c.hue) * 6;
    sec  = sector_e'(3'(six >> HueW));
    frac = six & (one - 1);
    full = 255 * one;
    v    = c.val;
    s    = c.sat;
    p    = (v * (255 - s)) / 255;
    q    = (v * (full - s * frac)) / full;
    t    = (v * (full - s * (one - frac))) / full;
    case (sec)
      SEC_RED_YEL: res = '{red: v[7:0], green: t[7:0], blue: p[7:0]};
      SEC_YEL_GRN: res = '{red: q[7:0], green: v[7:0], blue: p[7:0]};
      SEC_GRN_CYN: res = '{red: p[7:0], green: v[7:0], blue: t[7:0]};
      SEC_CYN_BLU: res = '{red: p[7:0], green: q[7:0], blue: v[7:0]};
      SEC_BLU_MAG: res = '{red: t[7:0], green: p[7:0], blue: v[7:0]};
      default:     res = '{red: v[7:0], green: p[7:0], blue: q[7:0]};
    endcase
    return res;
  endfunction

  // Pick a channel value at or next to an end or the middle of its range
  function automatic logic [ChanW-1:0] edge_chan();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd127;
      3:       return 8'd128;
      4:       return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // First hue code whose sector is k
  function automatic int unsigned sector_start(int unsigned k);
    return (k * (1 << HueW) + 5) / 6;
  endfunction

  task automatic queue_word(logic [HueW-1:0] h, logic [ChanW-1:0] s, logic [ChanW-1:0] v);
    pending_hsv.push_back('{hue: h, sat: s, val: v});
    words_queued++;
  endtask

  task automatic note_mismatch(string what, logic [ChanW-1:0] want, logic [ChanW-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: result %0d %s mismatch: expected %0d, got %0d",
               $realtime, words_checked, what, want, got);
    end
  endtask

  // Driver: launch queued words, hold while busy, idle a random number of cycles
  always @(posedge clk_i or negedge rst_ni) begin : drive_words
    hsv_t nxt;
    int unsigned sec;
    if (!rst_ni) begin
      start_i      <= 1'b0;
      hue_i        <= '0;
      saturation_i <= '0;
      brightness_i <= '0;
      gap_left      = 0;
    end else begin
      // Word taken at this edge: predict it now
      if (start_i && !busy_o) begin
        expected_rgb.push_back(hsv_to_rgb_predict('{hue: hue_i, sat: saturation_i,
                                                    val: brightness_i}));
        sec = (32'(hue_i) * 6) >> HueW;
        sector_hits[sec]++;
        words_taken++;
      end
      if (start_i && busy_o) begin
        // hold the word until the block takes it
      end else if (gap_left != 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (pending_hsv.size() != 0) begin
        nxt = pending_hsv.pop_front();
        hue_i        <= nxt.hue;
        saturation_i <= nxt.sat;
        brightness_i <= nxt.val;
        start_i      <= 1'b1;
        // Draw the pause after this word, with occasional stretches of none
        if (calm_left != 0) begin
          calm_left--;
          gap_left = 0;
        end else if ($urandom_range(0, 39) == 0) begin
          calm_left = $urandom_range(10, 50);
          gap_left  = 0;
        end else begin
          gap_left = $urandom_range(0, 7);
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: compare each strobed result with the oldest prediction
  always @(posedge clk_i) begin : check_words
    rgb_t want;
    if (rst_ni && valid_o) begin
      if (expected_rgb.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result strobed with no word outstanding: r=%0d g=%0d b=%0d",
                   $realtime, red_o, green_o, blue_o);
        end
      end else begin
        want = expected_rgb.pop_front();
        if (red_o !== want.red) note_mismatch("red", want.red, red_o);
        if (green_o !== want.green) note_mismatch("green", want.green, green_o);
        if (blue_o !== want.blue) note_mismatch("blue", want.blue, blue_o);
        words_checked++;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : stimulus
    int unsigned directed;
    int unsigned k;
    int unsigned kind;
    int          h;

    // Corners of the channel ranges and hue wrap
    queue_word('0, 8'd0, 8'd0);
    queue_word('0, 8'd255, 8'd255);
    queue_word('1, 8'd255, 8'd255);
    queue_word('1, 8'd0, 8'd255);
    queue_word(HueW'(1 << (HueW - 1)), 8'd255, 8'd0);
    queue_word('1, 8'd255, 8'd128);
    // Both sides of every sector boundary inside the turn
    for (k = 1; k < 6; k++) begin
      queue_word(HueW'(sector_start(k) - 1), 8'd255, 8'd255);
      queue_word(HueW'(sector_start(k)), 8'd255, 8'd255);
    end
    // Middle of every sector
    for (k = 0; k < 6; k++) begin
      queue_word(HueW'(((2 * k + 1) * (1 << HueW)) / 12), 8'd128, 8'd200);
    end
    queue_word(HueW'(32'h5555), 8'd1, 8'd254);
    queue_word(HueW'(32'hAAAA), 8'd254, 8'd1);
    directed = words_queued;

    // Random words: mostly uniform, some at channel ends and middles, or near boundaries
    repeat (RandWords) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        queue_word(HueW'($urandom), 8'($urandom), 8'($urandom));
      end else if (kind < 8) begin
        queue_word(HueW'($urandom), edge_chan(), edge_chan());
      end else begin
        h = int'(sector_start($urandom_range(0, 6))) + $urandom_range(0, 4) - 2;
        queue_word(HueW'(h), 8'($urandom), edge_chan());
      end
    end

    // Release reset
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all words taken, all results back, then a short quiet period
    while (words_taken != words_queued) @(posedge clk_i);
    while (expected_rgb.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Converted %0d words (%0d directed), %0d results checked, %0d mismatches",
             words_taken, directed, words_checked, mismatches);
    $display("Words per sector: %0d %0d %0d %0d %0d %0d", sector_hits[0], sector_hits[1],
             sector_hits[2], sector_hits[3], sector_hits[4], sector_hits[5]);
    if (mismatches == 0 && expected_rgb.size() == 0) begin
      $display("hsv_to_rgb_converter verification clean");
    end else begin
      $display("hsv_to_rgb_converter verification failed");
    end
    $finish;
  end

  // Hard stop in case results never arrive
  initial begin : watchdog
    #(2_000_000);
    $display("Timeout: %0d of %0d words taken, %0d results checked",
             words_taken, words_queued, words_checked);
    $display("hsv_to_rgb_converter verification failed");
    $finish;
  end

endmodule
